FILE: rtl/core/prl_pkg.sv
// -----------------------------------------------------------------------------
// prl_pkg
// Shared types, operation and status codes for the positional record list.
// -----------------------------------------------------------------------------
package prl_pkg;

   // Default list depth
   localparam int CAPACITY_DEF = 64;

   // Operation codes
   localparam logic [2:0] OP_INSERT  = 3'd0;
   localparam logic [2:0] OP_DELETE  = 3'd1;
   localparam logic [2:0] OP_READ    = 3'd2;
   localparam logic [2:0] OP_FIND    = 3'd3;
   localparam logic [2:0] OP_REPLACE = 3'd4;
   localparam logic [2:0] OP_SORT    = 3'd5;

   // Status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD       = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   // Name returned by a failed read
   localparam logic [63:0] NA_NAME = 64'h0000_0000_0000_414E;
   localparam logic signed [31:0] BAD_ID = -32'sd1;

   // One stored record
   typedef struct packed {
      logic signed [31:0] card_id;
      logic [63:0]        name_a;
      logic [63:0]        name_b;
      logic [31:0]        name_c;
   } rec_type;

   // Request transaction
   typedef struct packed {
      logic [2:0]         op;
      logic [6:0]         pos;
      logic signed [31:0] card_id;
      logic [63:0]        name_bytes_a;
      logic [63:0]        name_bytes_b;
      logic [31:0]        name_bytes_c;
   } req_type;

   // Response transaction
   typedef struct packed {
      logic [1:0]         status;
      logic [5:0]         found_index;
      logic signed [31:0] read_id;
      logic [63:0]        read_name_a;
      logic [63:0]        read_name_b;
      logic [31:0]        read_name_c;
      logic [6:0]         entry_count;
      logic               list_full;
   } rsp_type;

endpackage

FILE: rtl/core/prl_ram.sv
// -----------------------------------------------------------------------------
// prl_ram
// Generic single-write, single-read RAM with a registered read port.
// -----------------------------------------------------------------------------
module prl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/prl_ctrl.sv
// -----------------------------------------------------------------------------
// prl_ctrl
// Sequencer: runs each operation as reads and writes on the record RAM and
// holds the entry count and the response register.
// -----------------------------------------------------------------------------
module prl_ctrl #(
   parameter int CAPACITY = prl_pkg::CAPACITY_DEF,
   localparam int AW = $clog2(CAPACITY)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  prl_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output prl_pkg::rsp_type  rsp_data,
   output logic              mem_wr_en,
   output logic [AW-1:0]     mem_wr_addr,
   output prl_pkg::rec_type  mem_wr_data,
   output logic [AW-1:0]     mem_rd_addr,
   input  prl_pkg::rec_type  mem_rd_data
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW + 1 > 7) ? CW + 1 : 7;

   typedef enum logic [12:0] {
      ST_IDLE      = 13'b0000000000001,
      ST_MOVE_RD   = 13'b0000000000010,
      ST_MOVE_WR   = 13'b0000000000100,
      ST_PUT       = 13'b0000000001000,
      ST_READ_WAIT = 13'b0000000010000,
      ST_FIND_RD   = 13'b0000000100000,
      ST_FIND_CMP  = 13'b0000001000000,
      ST_SCAN_RD   = 13'b0000010000000,
      ST_SCAN_CMP  = 13'b0000100000000,
      ST_SWAP_RDI  = 13'b0001000000000,
      ST_SWAP_RDB  = 13'b0010000000000,
      ST_SWAP_WRI  = 13'b0100000000000,
      ST_SWAP_WRB  = 13'b1000000000000
   } state_type;

   localparam state_type ST_RESP_LOAD = ST_IDLE;

   state_type          state_ff, state_in;
   logic               resp_pend_ff, resp_pend_in;
   prl_pkg::req_type   req_ff, req_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [AW-1:0]      jdx_ff, jdx_in;
   logic [AW-1:0]      best_ff, best_in;
   logic signed [31:0] best_id_ff, best_id_in;
   prl_pkg::rec_type   tmp_ff, tmp_in;
   logic [CW-1:0]      count_ff, count_in;
   prl_pkg::rsp_type   res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   prl_pkg::rsp_type   rsp_ff, rsp_in;

   logic [XW-1:0]      in_pos_x;
   logic [XW-1:0]      held_pos_x;
   logic [XW-1:0]      count_x;
   logic [XW-1:0]      idx_x;
   logic [AW-1:0]      in_pos_a;
   logic [AW-1:0]      held_pos_a;
   logic               key_match;
   logic               out_free;

   assign in_pos_x   = XW'(req_data.pos);
   assign held_pos_x = XW'(req_ff.pos);
   assign count_x    = XW'(count_ff);
   assign idx_x      = XW'(idx_ff);
   assign in_pos_a   = AW'(in_pos_x);
   assign held_pos_a = AW'(held_pos_x);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Whole-record compare for find
   assign key_match = (mem_rd_data.card_id == req_ff.card_id) &&
                      (mem_rd_data.name_a == req_ff.name_bytes_a) &&
                      (mem_rd_data.name_b == req_ff.name_bytes_b) &&
                      (mem_rd_data.name_c == req_ff.name_bytes_c);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      resp_pend_in = resp_pend_ff;
      req_in       = req_ff;
      idx_in       = idx_ff;
      jdx_in       = jdx_ff;
      best_in      = best_ff;
      best_id_in   = best_id_ff;
      tmp_in       = tmp_ff;
      count_in     = count_ff;
      res_in       = res_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = idx_ff;
      mem_wr_data  = mem_rd_data;
      mem_rd_addr  = idx_ff;

      case (state_ff)
         ST_IDLE: begin
            mem_rd_addr = in_pos_a;
            if (!resp_pend_ff && req_valid) begin
               req_in = req_data;
               res_in = '0;
               resp_pend_in = 1'b1;
               case (req_data.op)
                  prl_pkg::OP_INSERT: begin
                     if (count_x >= XW'(CAPACITY) || in_pos_x > count_x) begin
                        res_in.status = prl_pkg::STATUS_BAD;
                     end else begin
                        resp_pend_in = 1'b0;
                        idx_in = AW'(count_ff);
                        state_in = (in_pos_x == count_x) ? ST_PUT : ST_MOVE_RD;
                     end
                  end
                  prl_pkg::OP_DELETE: begin
                     if (in_pos_x >= count_x) begin
                        res_in.status = prl_pkg::STATUS_BAD;
                     end else if (in_pos_x + XW'(1) == count_x) begin
                        count_in = count_ff - CW'(1);
                     end else begin
                        resp_pend_in = 1'b0;
                        idx_in = in_pos_a;
                        state_in = ST_MOVE_RD;
                     end
                  end
                  prl_pkg::OP_READ: begin
                     if (in_pos_x >= count_x) begin
                        res_in.status = prl_pkg::STATUS_BAD;
                        res_in.read_id = prl_pkg::BAD_ID;
                        res_in.read_name_a = prl_pkg::NA_NAME;
                     end else begin
                        resp_pend_in = 1'b0;
                        state_in = ST_READ_WAIT;
                     end
                  end
                  prl_pkg::OP_FIND: begin
                     if (count_ff == '0) begin
                        res_in.status = prl_pkg::STATUS_NOT_FOUND;
                     end else begin
                        resp_pend_in = 1'b0;
                        idx_in = '0;
                        state_in = ST_FIND_RD;
                     end
                  end
                  prl_pkg::OP_REPLACE: begin
                     if (in_pos_x >= count_x) begin
                        res_in.status = prl_pkg::STATUS_BAD;
                     end else begin
                        resp_pend_in = 1'b0;
                        state_in = ST_PUT;
                     end
                  end
                  prl_pkg::OP_SORT: begin
                     if (count_ff != '0) begin
                        resp_pend_in = 1'b0;
                        idx_in = '0;
                        jdx_in = '0;
                        state_in = ST_SCAN_RD;
                     end
                  end
                  default: begin
                     res_in.status = prl_pkg::STATUS_BAD;
                  end
               endcase
            end else if (resp_pend_ff && out_free) begin
               resp_pend_in = 1'b0;
            end
         end

         // Shift one entry: up for insert, down for delete
         ST_MOVE_RD: begin
            mem_rd_addr = (req_ff.op == prl_pkg::OP_INSERT) ? idx_ff - AW'(1)
                                                            : idx_ff + AW'(1);
            state_in = ST_MOVE_WR;
         end
         ST_MOVE_WR: begin
            mem_wr_en = 1'b1;
            if (req_ff.op == prl_pkg::OP_INSERT) begin
               idx_in = idx_ff - AW'(1);
               state_in = (idx_x - XW'(1) == held_pos_x) ? ST_PUT : ST_MOVE_RD;
            end else if (idx_x + XW'(2) < count_x) begin
               idx_in = idx_ff + AW'(1);
               state_in = ST_MOVE_RD;
            end else begin
               count_in = count_ff - CW'(1);
               resp_pend_in = 1'b1;
               state_in = ST_IDLE;
            end
         end

         // Write the new record at the requested position
         ST_PUT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = held_pos_a;
            mem_wr_data = '{req_ff.card_id, req_ff.name_bytes_a,
                            req_ff.name_bytes_b, req_ff.name_bytes_c};
            if (req_ff.op == prl_pkg::OP_INSERT) begin
               count_in = count_ff + CW'(1);
            end
            resp_pend_in = 1'b1;
            state_in = ST_IDLE;
         end

         ST_READ_WAIT: begin
            res_in.read_id     = mem_rd_data.card_id;
            res_in.read_name_a = mem_rd_data.name_a;
            res_in.read_name_b = mem_rd_data.name_b;
            res_in.read_name_c = mem_rd_data.name_c;
            resp_pend_in = 1'b1;
            state_in = ST_IDLE;
         end

         // Linear search from the head
         ST_FIND_RD: begin
            state_in = ST_FIND_CMP;
         end
         ST_FIND_CMP: begin
            if (key_match) begin
               res_in.found_index = 6'(idx_ff);
               resp_pend_in = 1'b1;
               state_in = ST_IDLE;
            end else if (idx_x + XW'(1) == count_x) begin
               res_in.status = prl_pkg::STATUS_NOT_FOUND;
               resp_pend_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + AW'(1);
               state_in = ST_FIND_RD;
            end
         end

         // Selection sort: scan for the first minimum, then swap
         ST_SCAN_RD: begin
            mem_rd_addr = jdx_ff;
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (jdx_ff == idx_ff || best_id_ff > mem_rd_data.card_id) begin
               best_in = jdx_ff;
               best_id_in = mem_rd_data.card_id;
            end
            if (XW'(jdx_ff) + XW'(1) == count_x) begin
               state_in = ST_SWAP_RDI;
            end else begin
               jdx_in = jdx_ff + AW'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_SWAP_RDI: begin
            state_in = ST_SWAP_RDB;
         end
         ST_SWAP_RDB: begin
            tmp_in = mem_rd_data;
            mem_rd_addr = best_ff;
            state_in = ST_SWAP_WRI;
         end
         ST_SWAP_WRI: begin
            mem_wr_en = 1'b1;
            state_in = ST_SWAP_WRB;
         end
         ST_SWAP_WRB: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = best_ff;
            mem_wr_data = tmp_ff;
            if (idx_x + XW'(1) == count_x) begin
               resp_pend_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + AW'(1);
               jdx_in = idx_ff + AW'(1);
               state_in = ST_SCAN_RD;
            end
         end

         default: begin
            state_in = ST_RESP_LOAD;
         end
      endcase
   end

   // Response register: load a finished result once the slot is free
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (state_ff == ST_IDLE && resp_pend_ff && out_free) begin
         rsp_in             = res_ff;
         rsp_in.entry_count = 7'(count_ff);
         rsp_in.list_full   = (XW'(count_ff) == XW'(CAPACITY));
         rsp_valid_in       = 1'b1;
      end
   end

   assign req_stall = (state_ff != ST_IDLE) || resp_pend_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         resp_pend_ff <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         resp_pend_ff <= resp_pend_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      idx_ff     <= idx_in;
      jdx_ff     <= jdx_in;
      best_ff    <= best_in;
      best_id_ff <= best_id_in;
      tmp_ff     <= tmp_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

endmodule

FILE: rtl/core/positional_record_list_top.sv
// -----------------------------------------------------------------------------
// positional_record_list_top
// Ordered list of id/name records held in one RAM, with insert, delete,
// read, find, replace and selection sort by signed id.
// -----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_valid/req_stall/req_data, one transaction per
//   operation; each gives exactly one response on rsp_valid/rsp_stall/rsp_data.
//   The block works on one transaction at a time; req_stall is high while an
//   operation runs or its response cannot yet be placed in the output register.
//   Each operation works through the single record RAM. Rejected operations,
//   delete of the last entry and empty find or sort need no RAM access;
//   read and replace use one access; insert and delete shift one entry at a
//   time by a read and a write; find examines entries from the head; sort is
//   a selection sort over all entries.
//   The next request is taken in the cycle after a response is loaded into
//   the output register, so a new transaction starts only when the last is done.
//   A response waits in its output register while rsp_stall is high; the next
//   request is still accepted and runs, and its result is loaded once the
//   register is taken.
//   Reset empties the list at once (count to zero); RAM contents are not
//   cleared, so no clearing pass is needed.
// -----------------------------------------------------------------------------
module positional_record_list_top #(
   parameter int CAPACITY = prl_pkg::CAPACITY_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  prl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output prl_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(CAPACITY);

   logic             mem_wr_en;
   logic [AW-1:0]    mem_wr_addr;
   prl_pkg::rec_type mem_wr_data;
   logic [AW-1:0]    mem_rd_addr;
   prl_pkg::rec_type mem_rd_data;

   // Operation sequencer
   prl_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // Record store
   prl_ram #(
      .WIDTH ($bits(prl_pkg::rec_type)),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

FILE: tb/sv/tb_positional_record_list_top.sv
// -----------------------------------------------------------------------------
// tb_positional_record_list_top
// Self-checking testbench for the positional record list: drives insert,
// delete, read, find, replace and sort transactions, predicts every response
// from a local copy of the list and compares each response field by field.
// -----------------------------------------------------------------------------
module tb_positional_record_list_top;
   timeunit 1ns;
   timeprecision 1ps;

   import prl_pkg::*;

   localparam int CAP = 64;
   localparam int CYCLE_LIMIT = 4000000;
   localparam logic [2:0] OP_ILLEGAL_6 = 3'd6;
   localparam logic [2:0] OP_ILLEGAL_7 = 3'd7;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // shadow list held by the predictor
   rec_type list_recs[CAP];
   int      list_len;

   rsp_type pending_rsps[$];
   int      error_count;
   int      cycle_count;
   bit      src_idle_en;
   bit      sink_idle_en;
   int      sink_hold_cycles;

   positional_record_list_top #(.CAPACITY(CAP)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // clock generation
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // Work out the response for one transaction and advance the shadow list.
   function automatic rsp_type predict_list_op(input req_type rq);
      rsp_type r;
      rec_type nr;
      rec_type tmp;
      int      best;
      r = '0;
      nr.card_id = rq.card_id;
      nr.name_a  = rq.name_bytes_a;
      nr.name_b  = rq.name_bytes_b;
      nr.name_c  = rq.name_bytes_c;
      case (rq.op)
         OP_INSERT: begin
            if (list_len >= CAP || rq.pos > list_len) begin
               r.status = STATUS_BAD;
            end else begin
               for (int i = list_len; i > rq.pos; i--) list_recs[i] = list_recs[i-1];
               list_recs[rq.pos] = nr;
               list_len++;
            end
         end
         OP_DELETE: begin
            if (rq.pos >= list_len) begin
               r.status = STATUS_BAD;
            end else begin
               for (int i = rq.pos; i + 1 < list_len; i++) list_recs[i] = list_recs[i+1];
               list_len--;
            end
         end
         OP_READ: begin
            if (rq.pos >= list_len) begin
               r.status  = STATUS_BAD;
               r.read_id = BAD_ID;
               r.read_name_a = NA_NAME;
            end else begin
               r.read_id     = list_recs[rq.pos].card_id;
               r.read_name_a = list_recs[rq.pos].name_a;
               r.read_name_b = list_recs[rq.pos].name_b;
               r.read_name_c = list_recs[rq.pos].name_c;
            end
         end
         OP_FIND: begin
            r.status = STATUS_NOT_FOUND;
            for (int i = 0; i < list_len; i++) begin
               if (list_recs[i] == nr) begin
                  r.status = STATUS_OK;
                  r.found_index = i[5:0];
                  break;
               end
            end
         end
         OP_REPLACE: begin
            if (rq.pos >= list_len) r.status = STATUS_BAD;
            else list_recs[rq.pos] = nr;
         end
         OP_SORT: begin
            for (int i = 0; i < list_len; i++) begin
               best = i;
               for (int j = i + 1; j < list_len; j++)
                  if (list_recs[best].card_id > list_recs[j].card_id) best = j;
               tmp = list_recs[i];
               list_recs[i] = list_recs[best];
               list_recs[best] = tmp;
            end
         end
         default: r.status = STATUS_BAD;
      endcase
      r.entry_count = list_len[6:0];
      r.list_full   = (list_len == CAP);
      return r;
   endfunction

   // Offer one transaction, hold it until accepted, then predict.
   task automatic send_list_op(input req_type rq);
      int gap;
      if (src_idle_en && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (req_stall);
      pending_rsps.push_back(predict_list_op(rq));
      @(negedge clock);
   endtask

   function automatic req_type make_op(input logic [2:0] op, input int pos,
                                       input logic [31:0] id, input logic [63:0] a,
                                       input logic [63:0] b, input logic [31:0] c);
      req_type rq;
      rq.op = op;
      rq.pos = pos[6:0];
      rq.card_id = id;
      rq.name_bytes_a = a;
      rq.name_bytes_b = b;
      rq.name_bytes_c = c;
      return rq;
   endfunction

   function automatic req_type random_op();
      req_type rq;
      int      k;
      k = $urandom_range(0, 99);
      rq.card_id = (k < 50) ? 32'($urandom_range(0, 15) - 8) : 32'($urandom);
      rq.name_bytes_a = {$urandom, $urandom};
      rq.name_bytes_b = ($urandom_range(0, 1)) ? {$urandom, $urandom} : 64'd0;
      rq.name_bytes_c = ($urandom_range(0, 1)) ? $urandom : 32'd0;
      rq.pos = (list_len > 0 && $urandom_range(0, 5) != 0) ?
               7'($urandom_range(0, list_len)) : 7'($urandom_range(0, 127));
      if (k < 35) rq.op = OP_INSERT;
      else if (k < 50) rq.op = OP_DELETE;
      else if (k < 68) rq.op = OP_READ;
      else if (k < 80) rq.op = OP_FIND;
      else if (k < 90) rq.op = OP_REPLACE;
      else if (k < 95) rq.op = OP_SORT;
      else rq.op = 3'($urandom_range(0, 7));
      // aim some finds at a stored record
      if (rq.op == OP_FIND && list_len > 0 && $urandom_range(0, 1)) begin
         k = $urandom_range(0, list_len - 1);
         rq.card_id = list_recs[k].card_id;
         rq.name_bytes_a = list_recs[k].name_a;
         rq.name_bytes_b = list_recs[k].name_b;
         rq.name_bytes_c = list_recs[k].name_c;
      end
      return rq;
   endfunction

   // Drop the request and wait until every expected response has come.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(negedge clock);
   endtask

   // Response sink: random stalls plus an optional long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (sink_hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         sink_hold_cycles <= sink_hold_cycles - 1;
      end else if (sink_idle_en && $urandom_range(0, 9) == 0) begin
         rsp_stall <= 1'b1;
         sink_hold_cycles <= $urandom_range(0, 16);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each accepted response with the oldest prediction.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsps.size() == 0) begin
            report_mismatch("response with nothing expected");
         end else begin
            e = pending_rsps.pop_front();
            if (rsp_data.status !== e.status)
               report_mismatch($sformatf("status %0d exp %0d", rsp_data.status, e.status));
            if (rsp_data.found_index !== e.found_index)
               report_mismatch($sformatf("found_index %0d exp %0d",
                                         rsp_data.found_index, e.found_index));
            if (rsp_data.read_id !== e.read_id)
               report_mismatch($sformatf("read_id %0d exp %0d", rsp_data.read_id, e.read_id));
            if (rsp_data.read_name_a !== e.read_name_a)
               report_mismatch($sformatf("read_name_a %h exp %h",
                                         rsp_data.read_name_a, e.read_name_a));
            if (rsp_data.read_name_b !== e.read_name_b)
               report_mismatch($sformatf("read_name_b %h exp %h",
                                         rsp_data.read_name_b, e.read_name_b));
            if (rsp_data.read_name_c !== e.read_name_c)
               report_mismatch($sformatf("read_name_c %h exp %h",
                                         rsp_data.read_name_c, e.read_name_c));
            if (rsp_data.entry_count !== e.entry_count)
               report_mismatch($sformatf("entry_count %0d exp %0d",
                                         rsp_data.entry_count, e.entry_count));
            if (rsp_data.list_full !== e.list_full)
               report_mismatch($sformatf("list_full %0d exp %0d",
                                         rsp_data.list_full, e.list_full));
         end
      end
   end

   // Directed: empty-list errors, extremes, every operation and bad op codes.
   task automatic test_directed();
      send_list_op(make_op(OP_READ, 0, 0, 0, 0, 0));
      send_list_op(make_op(OP_DELETE, 0, 0, 0, 0, 0));
      send_list_op(make_op(OP_REPLACE, 0, 0, 0, 0, 0));
      send_list_op(make_op(OP_FIND, 0, 5, 1, 0, 0));
      send_list_op(make_op(OP_INSERT, 1, 3, 1, 0, 0));
      send_list_op(make_op(OP_INSERT, 0, 32'h7FFF_FFFF, '1, '1, '1));
      send_list_op(make_op(OP_INSERT, 0, 32'h8000_0000, 64'h414E, 0, 0));
      send_list_op(make_op(OP_INSERT, 2, 0, 64'h0041_4243, 0, 0));
      send_list_op(make_op(OP_INSERT, 1, -1, 64'h0041_4243, 64'h1, 0));
      send_list_op(make_op(OP_READ, 0, 0, 0, 0, 0));
      send_list_op(make_op(OP_READ, 3, 0, 0, 0, 0));
      send_list_op(make_op(OP_READ, 4, 0, 0, 0, 0));
      send_list_op(make_op(OP_READ, 127, 0, 0, 0, 0));
      send_list_op(make_op(OP_FIND, 0, 0, 64'h0041_4243, 0, 0));
      send_list_op(make_op(OP_FIND, 0, 0, 64'h0041_4243, 64'h1, 0));
      send_list_op(make_op(OP_FIND, 0, 32'h7FFF_FFFF, '1, '1, '1));
      send_list_op(make_op(OP_SORT, 0, 0, 0, 0, 0));
      send_list_op(make_op(OP_READ, 0, 0, 0, 0, 0));
      send_list_op(make_op(OP_REPLACE, 3, 7, 64'h55, 0, 32'h1));
      send_list_op(make_op(OP_REPLACE, 4, 7, 0, 0, 0));
      send_list_op(make_op(OP_DELETE, 0, 0, 0, 0, 0));
      send_list_op(make_op(OP_DELETE, 100, 0, 0, 0, 0));
      send_list_op(make_op(OP_ILLEGAL_6, 0, 0, 0, 0, 0));
      send_list_op(make_op(OP_ILLEGAL_7, 0, 0, 0, 0, 0));
      wait_drained();
   endtask

   // Fill to capacity under a long receiver hold-off, overflow, sort, then delete down to four entries.
   task automatic test_full_list();
      sink_hold_cycles = 400;
      while (list_len < CAP)
         send_list_op(make_op(OP_INSERT, $urandom_range(0, list_len), $urandom,
                              {$urandom, $urandom}, {$urandom, $urandom}, $urandom));
      send_list_op(make_op(OP_INSERT, 0, 1, 1, 1, 1));
      send_list_op(make_op(OP_INSERT, CAP, 1, 1, 1, 1));
      send_list_op(make_op(OP_READ, CAP - 1, 0, 0, 0, 0));
      send_list_op(make_op(OP_SORT, 0, 0, 0, 0, 0));
      send_list_op(make_op(OP_DELETE, CAP - 1, 0, 0, 0, 0));
      send_list_op(make_op(OP_DELETE, 0, 0, 0, 0, 0));
      wait_drained();
      while (list_len > 4) send_list_op(make_op(OP_DELETE, $urandom_range(0, list_len - 1),
                                                0, 0, 0, 0));
      wait_drained();
   endtask

   task automatic test_random(input int n);
      for (int i = 0; i < n; i++) send_list_op(random_op());
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      list_len = 0;
      error_count = 0;
      cycle_count = 0;
      src_idle_en = 1'b0;
      sink_idle_en = 1'b0;
      sink_hold_cycles = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      src_idle_en = 1'b1;
      sink_idle_en = 1'b1;
      test_full_list();
      test_random(240);
      wait_drained();
      src_idle_en = 1'b0;
      sink_idle_en = 1'b0;
      test_random(60);

      wait_drained();
      repeat (50) @(negedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
